// File: rtl/lacd_pkg.sv
// Package for the locality-aware cluster dispatcher.
// Holds field widths, operation and operand codes and the pipeline class map.
// No dependencies.
`default_nettype none

package lacd_pkg;

    localparam int OP_W    = 3;
    localparam int ID_W    = 10;
    localparam int SK_W    = 2;
    localparam int TC_W    = 4;
    localparam int CFG_W   = 5;
    localparam int CLASSES = 4;
    localparam int CLS_W   = 2;
    localparam int APB_AW  = 2;
    localparam int APB_DW  = 32;

    localparam logic [APB_AW-1:0] ADDR_CLUSTERS_IN_USE = 2'd0;
    localparam logic [CFG_W-1:0]  CLUSTERS_RESET       = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_NTT    = 3'd0,
        OP_INTT   = 3'd1,
        OP_MODMUL = 3'd2,
        OP_MODADD = 3'd3,
        OP_LOAD   = 3'd4,
        OP_OTHER  = 3'd5
    } op_kind_t;

    typedef enum logic [SK_W-1:0] {
        SRC_ABSENT  = 2'd0,
        SRC_LITERAL = 2'd1,
        SRC_DATA    = 2'd2
    } src_kind_t;

    typedef enum logic [CLS_W-1:0] {
        CLS_MISC   = 2'd0,
        CLS_XFORM  = 2'd1,
        CLS_MODMUL = 2'd2,
        CLS_MODADD = 2'd3
    } pipe_class_t;

    // Map an operation code onto its pipeline class; loads, other ops and unknown codes are misc.
    function automatic logic [CLS_W-1:0] pipe_class(input logic [OP_W-1:0] kind);
        logic [CLS_W-1:0] c;
        case (kind) inside
            OP_NTT, OP_INTT: c = CLS_XFORM;
            OP_MODMUL:       c = CLS_MODMUL;
            OP_MODADD:       c = CLS_MODADD;
            default:         c = CLS_MISC;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/lacd_if.sv
// Valid/ready channel interfaces for the dispatcher: instruction in, result out.
// Depends on lacd_pkg for field widths.
`default_nettype none

interface lacd_in_if;
    import lacd_pkg::*;
    logic            valid;
    logic            ready;
    logic [OP_W-1:0] op_kind;
    logic [ID_W-1:0] src0_id;
    logic [SK_W-1:0] src0_kind;
    logic [ID_W-1:0] src1_id;
    logic [SK_W-1:0] src1_kind;
    logic [ID_W-1:0] src2_id;
    logic [SK_W-1:0] src2_kind;
    logic [ID_W-1:0] dst_id;

    modport source (output valid, op_kind, src0_id, src0_kind, src1_id, src1_kind,
                    src2_id, src2_kind, dst_id, input ready);
    modport sink   (input valid, op_kind, src0_id, src0_kind, src1_id, src1_kind,
                    src2_id, src2_kind, dst_id, output ready);
endinterface

interface lacd_out_if;
    import lacd_pkg::*;
    logic            valid;
    logic            ready;
    logic            is_load;
    logic [TC_W-1:0] target_cluster;
    logic [ID_W-1:0] loaded_id;
    logic            last;

    modport source (output valid, is_load, target_cluster, loaded_id, last, input ready);
    modport sink   (input valid, is_load, target_cluster, loaded_id, last, output ready);
endinterface

`default_nettype wire

// File: rtl/locality_aware_cluster_dispatcher.sv
// Locality-aware cluster dispatcher: one instruction at a time, 1 to 4 results each.
// Each instruction runs reduce, location reads, a cluster scan, a misc counter fetch,
// result emission (held by output stalls) and counter write-back; the scan reads one cluster per cycle.
// Reset (rst_n, async low) runs a clearing pass over the location and counter RAMs
// before the first instruction. Uses lacd_pkg, lacd_if, lacd_ram.
`default_nettype none

module locality_aware_cluster_dispatcher
    import lacd_pkg::*;
#(
    parameter int N_CLUSTERS   = 16,
    parameter int DATA_IDS     = 1024,
    parameter int MAX_SOURCES  = 3,
    parameter int COUNT_BITS   = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    lacd_in_if.sink           instr,
    lacd_out_if.source        result
);

    localparam int CW    = (N_CLUSTERS > 1) ? $clog2(N_CLUSTERS) : 1;
    localparam int EW    = $clog2(N_CLUSTERS + 1);
    localparam int AW    = $clog2(DATA_IDS);
    localparam int LW    = CW + 1;
    localparam int KW    = CW + CLS_W;
    localparam int KD    = N_CLUSTERS * CLASSES;
    localparam int CLR_N = (DATA_IDS > KD) ? DATA_IDS : KD;
    localparam int CLW   = $clog2(CLR_N);
    // Index reduction id mod DATA_IDS: reciprocal estimate, then one correction.
    localparam int SH    = 20;
    localparam int RECIP = (1 << SH) / DATA_IDS;
    localparam int RW    = 28;
    localparam int NSRC  = 3;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RED, S_RD, S_RDW, S_SCAN, S_C0, S_C0W, S_EMIT, S_UPD0, S_UPD1
    } state_t;

    function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] v,
                                                      input logic [2:0] k);
        logic [COUNT_BITS:0] s;
        s = {1'b0, v} + (COUNT_BITS+1)'(k);
        return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
    endfunction

    state_t              state_reg;
    logic [CLW-1:0]      clr_reg;
    logic [CFG_W-1:0]    cfg_reg;
    logic [CLS_W-1:0]    cls_reg;
    logic [ID_W-1:0]     id_reg   [NSRC+1];
    logic [ID_W-1:0]     q_reg    [NSRC+1];
    logic [AW-1:0]       idx_reg  [NSRC+1];
    logic [NSRC-1:0]     used_reg;
    logic [1:0]          ptr_reg;
    logic [NSRC-1:0]     locv_reg;
    logic [CW-1:0]       locc_reg [NSRC];
    logic [EW-1:0]       scan_reg;
    logic                cmpv_reg;
    logic [CW-1:0]       cmpc_reg;
    logic                have_reg;
    logic [CW-1:0]       best_reg;
    logic [COUNT_BITS-1:0] bpipe_reg;
    logic [COUNT_BITS-1:0] btot_reg;
    logic [COUNT_BITS-1:0] c0_reg;
    logic [NSRC-1:0]     need_reg;
    logic [NSRC-1:0]     wr_reg;
    logic [1:0]          nld_reg;
    logic                out_v_reg;
    logic                out_load_reg;
    logic [TC_W-1:0]     out_tc_reg;
    logic [ID_W-1:0]     out_id_reg;
    logic                out_last_reg;

    // RAM ports
    logic                  loc_we;
    logic [AW-1:0]         loc_waddr;
    logic [LW-1:0]         loc_wdata;
    logic [LW-1:0]         loc_rdata;
    logic                  cls_we;
    logic [KW-1:0]         cls_waddr;
    logic [COUNT_BITS-1:0] cls_wdata;
    logic [KW-1:0]         cls_raddr;
    logic [COUNT_BITS-1:0] cls_rdata;
    logic                  tot_we;
    logic [CW-1:0]         tot_waddr;
    logic [COUNT_BITS-1:0] tot_wdata;
    logic [COUNT_BITS-1:0] tot_rdata;

    logic [EW-1:0]   eff;
    logic [NSRC-1:0] elig;
    logic [1:0]      mult [NSRC];
    logic [1:0]      maxc;
    logic            cand;
    logic [NSRC-1:0] dupinv;
    logic [NSRC-1:0] need_c;
    logic [NSRC-1:0] wr_c;
    logic            can_load;
    logic            emit_fire;
    logic            accept;
    logic [ID_W-1:0] in_ids [NSRC+1];
    logic [SK_W-1:0] in_kinds [NSRC];
    logic [ID_W-1:0] q_c [NSRC+1];
    logic [AW-1:0]   idx_c [NSRC+1];

    lacd_ram #(.WIDTH(LW), .DEPTH(DATA_IDS), .AW(AW)) u_loc (
        .clk   (clk),
        .we    (loc_we),
        .waddr (loc_waddr),
        .wdata (loc_wdata),
        .raddr (idx_reg[ptr_reg]),
        .rdata (loc_rdata)
    );

    lacd_ram #(.WIDTH(COUNT_BITS), .DEPTH(KD), .AW(KW)) u_cls (
        .clk   (clk),
        .we    (cls_we),
        .waddr (cls_waddr),
        .wdata (cls_wdata),
        .raddr (cls_raddr),
        .rdata (cls_rdata)
    );

    lacd_ram #(.WIDTH(COUNT_BITS), .DEPTH(N_CLUSTERS), .AW(CW)) u_tot (
        .clk   (clk),
        .we    (tot_we),
        .waddr (tot_waddr),
        .wdata (tot_wdata),
        .raddr (scan_reg[CW-1:0]),
        .rdata (tot_rdata)
    );

    // APB config register, always ready; the user must write it only while idle; not enforced here
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CLUSTERS_IN_USE) ? APB_DW'(cfg_reg) : '0;

    // Clamp clusters in use to 1..N_CLUSTERS
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            eff = EW'(1);
        end
        else if (int'(cfg_reg) > N_CLUSTERS)
        begin
            eff = EW'(N_CLUSTERS);
        end
        else
        begin
            eff = EW'(cfg_reg);
        end
    end

    assign accept    = instr.valid && instr.ready;
    assign can_load  = !out_v_reg || result.ready;
    // A result register load happens for a needed load slot or the final record
    assign emit_fire = (state_reg == S_EMIT) && can_load &&
                       ((ptr_reg == 2'd3) || need_reg[ptr_reg]);

    assign instr.ready           = (state_reg == S_IDLE);
    assign result.valid          = out_v_reg;
    assign result.is_load        = out_load_reg;
    assign result.target_cluster = out_tc_reg;
    assign result.loaded_id      = out_id_reg;
    assign result.last           = out_last_reg;

    assign in_ids[0]   = instr.src0_id;
    assign in_ids[1]   = instr.src1_id;
    assign in_ids[2]   = instr.src2_id;
    assign in_ids[3]   = instr.dst_id;
    assign in_kinds[0] = instr.src0_kind;
    assign in_kinds[1] = instr.src1_kind;
    assign in_kinds[2] = instr.src2_kind;

    // Index reduction: quotient estimate at accept, correction in the following S_RED state
    always_comb
    begin
        logic [RW-1:0] r;
        for (int k = 0; k <= NSRC; k++)
        begin
            q_c[k] = ID_W'((RW'(in_ids[k]) * RW'(RECIP)) >> SH);
            r = RW'(id_reg[k]) - RW'(q_reg[k]) * RW'(DATA_IDS);
            if (r >= RW'(DATA_IDS))
            begin
                r = r - RW'(DATA_IDS);
            end
            idx_c[k] = AW'(r);
        end
    end

    // Locality: a source counts only when resident on a cluster in use.
    // A cluster is a candidate when its count matches the highest count,
    // or always when no source counts.
    always_comb
    begin
        for (int s = 0; s < NSRC; s++)
        begin
            elig[s] = used_reg[s] && locv_reg[s] && (locc_reg[s] < eff);
        end
        maxc = '0;
        for (int s = 0; s < NSRC; s++)
        begin
            mult[s] = '0;
            for (int t = 0; t < NSRC; t++)
            begin
                if (elig[s] && elig[t] && locc_reg[t] == locc_reg[s])
                begin
                    mult[s] = mult[s] + 2'd1;
                end
            end
            if (mult[s] > maxc)
            begin
                maxc = mult[s];
            end
        end
        cand = (maxc == '0);
        for (int s = 0; s < NSRC; s++)
        begin
            if (elig[s] && mult[s] == maxc && locc_reg[s] == cmpc_reg)
            begin
                cand = 1'b1;
            end
        end
    end

    // Load decision per source. A repeated id that was absent is already
    // recorded on the chosen cluster by its earlier occurrence: no second load.
    always_comb
    begin
        for (int s = 0; s < NSRC; s++)
        begin
            dupinv[s] = 1'b0;
            for (int t = 0; t < s; t++)
            begin
                if (used_reg[t] && !locv_reg[t] && idx_reg[t] == idx_reg[s])
                begin
                    dupinv[s] = 1'b1;
                end
            end
            need_c[s] = used_reg[s] && !dupinv[s] && (!locv_reg[s] || locc_reg[s] != best_reg);
            wr_c[s]   = used_reg[s] && !dupinv[s] && !locv_reg[s];
        end
    end

    // RAM write and read address steering
    always_comb
    begin
        loc_we    = 1'b0;
        loc_waddr = idx_reg[ptr_reg];
        loc_wdata = {1'b1, best_reg};
        cls_we    = 1'b0;
        cls_waddr = {best_reg, CLS_W'(CLS_MISC)};
        cls_wdata = sat_add(c0_reg, 3'(nld_reg) + 3'(cls_reg == CLS_MISC));
        tot_we    = 1'b0;
        tot_waddr = best_reg;
        tot_wdata = sat_add(btot_reg, 3'(nld_reg) + 3'd1);
        cls_raddr = (state_reg == S_SCAN) ? {scan_reg[CW-1:0], cls_reg}
                                          : {best_reg, CLS_W'(CLS_MISC)};
        unique case (state_reg)
            S_CLEAR:
            begin
                loc_we    = (int'(clr_reg) < DATA_IDS);
                loc_waddr = clr_reg[AW-1:0];
                loc_wdata = '0;
                cls_we    = (int'(clr_reg) < KD);
                cls_waddr = clr_reg[KW-1:0];
                cls_wdata = '0;
                tot_we    = (int'(clr_reg) < N_CLUSTERS);
                tot_waddr = clr_reg[CW-1:0];
                tot_wdata = '0;
            end
            S_EMIT:
            begin
                if (can_load)
                begin
                    loc_we = (ptr_reg == 2'd3) || wr_reg[ptr_reg];
                end
            end
            S_UPD0:
            begin
                cls_we = 1'b1;
                tot_we = 1'b1;
            end
            S_UPD1:
            begin
                cls_we    = 1'b1;
                cls_waddr = {best_reg, cls_reg};
                cls_wdata = sat_add(bpipe_reg, 3'd1);
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer: clear RAMs after reset; then reduce ids, read three locations, scan
    // clusters, fetch the chosen cluster's misc counter, emit results, write counters back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            cfg_reg   <= CLUSTERS_RESET;
            out_v_reg <= 1'b0;
            ptr_reg   <= '0;
            cmpv_reg  <= 1'b0;
            have_reg  <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_CLUSTERS_IN_USE)
            begin
                cfg_reg <= pwdata[CFG_W-1:0];
            end
            // Hold the result until taken; a new one may replace it in the same cycle
            if (emit_fire)
            begin
                out_v_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_v_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + CLW'(1);
                    if (int'(clr_reg) == CLR_N - 1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cls_reg <= pipe_class(instr.op_kind);
                        for (int k = 0; k <= NSRC; k++)
                        begin
                            id_reg[k] <= in_ids[k];
                            q_reg[k]  <= q_c[k];
                        end
                        for (int s = 0; s < NSRC; s++)
                        begin
                            used_reg[s] <= (s < MAX_SOURCES) && (in_kinds[s] == SRC_DATA);
                        end
                        state_reg <= S_RED;
                    end
                end
                S_RED:
                begin
                    for (int k = 0; k <= NSRC; k++)
                    begin
                        idx_reg[k] <= idx_c[k];
                    end
                    ptr_reg   <= '0;
                    state_reg <= S_RD;
                end
                S_RD:
                begin
                    state_reg <= S_RDW;
                end
                S_RDW:
                begin
                    locv_reg[ptr_reg] <= loc_rdata[LW-1];
                    locc_reg[ptr_reg] <= loc_rdata[CW-1:0];
                    if (ptr_reg == 2'd2)
                    begin
                        ptr_reg   <= '0;
                        scan_reg  <= '0;
                        cmpv_reg  <= 1'b0;
                        have_reg  <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        ptr_reg   <= ptr_reg + 2'd1;
                        state_reg <= S_RD;
                    end
                end
                S_SCAN:
                begin
                    // issue cluster scan_reg, compare the one issued last cycle
                    cmpv_reg <= (scan_reg < eff);
                    cmpc_reg <= scan_reg[CW-1:0];
                    if (scan_reg < eff)
                    begin
                        scan_reg <= scan_reg + EW'(1);
                    end
                    if (cmpv_reg && cand &&
                        (!have_reg || cls_rdata < bpipe_reg ||
                         (cls_rdata == bpipe_reg && tot_rdata < btot_reg)))
                    begin
                        have_reg  <= 1'b1;
                        best_reg  <= cmpc_reg;
                        bpipe_reg <= cls_rdata;
                        btot_reg  <= tot_rdata;
                    end
                    if (scan_reg == eff && !cmpv_reg)
                    begin
                        state_reg <= S_C0;
                    end
                end
                S_C0:
                begin
                    state_reg <= S_C0W;
                end
                S_C0W:
                begin
                    c0_reg    <= cls_rdata;
                    need_reg  <= need_c;
                    wr_reg    <= wr_c;
                    nld_reg   <= 2'($countones(need_c));
                    ptr_reg   <= '0;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (can_load)
                    begin
                        if (ptr_reg == 2'd3)
                        begin
                            out_load_reg <= 1'b0;
                            out_tc_reg   <= TC_W'(best_reg);
                            out_id_reg   <= '0;
                            out_last_reg <= 1'b1;
                            ptr_reg      <= '0;
                            state_reg    <= S_UPD0;
                        end
                        else
                        begin
                            if (need_reg[ptr_reg])
                            begin
                                out_load_reg <= 1'b1;
                                out_tc_reg   <= TC_W'(best_reg);
                                out_id_reg   <= id_reg[ptr_reg];
                                out_last_reg <= 1'b0;
                            end
                            ptr_reg <= ptr_reg + 2'd1;
                        end
                    end
                end
                S_UPD0:
                begin
                    state_reg <= (cls_reg == CLS_MISC) ? S_IDLE : S_UPD1;
                end
                S_UPD1:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/lacd_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module lacd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/lacd_checker.sv
// Port-level checker for the dispatcher, bound to the top level.
// Depends on lacd_pkg for field widths.
`default_nettype none

module lacd_checker
    import lacd_pkg::*;
(
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            in_valid,
    input wire logic            in_ready,
    input wire logic            out_valid,
    input wire logic            out_ready,
    input wire logic            out_is_load,
    input wire logic [TC_W-1:0] out_tc,
    input wire logic [ID_W-1:0] out_id,
    input wire logic            out_last
);

    // One instruction in flight: ready drops right after a transaction
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("instruction taken while another is in flight");

    a_last_is_instr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |-> !out_is_load && out_id == '0)
        else $error("final result is not the instruction record");

    a_load_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_is_load |-> !out_last)
        else $error("load marked as final result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_tc) && $stable(out_id))
        else $error("stalled result changed");

endmodule

bind locality_aware_cluster_dispatcher lacd_checker u_lacd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (instr.valid),
    .in_ready    (instr.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_is_load (result.is_load),
    .out_tc      (result.target_cluster),
    .out_id      (result.loaded_id),
    .out_last    (result.last)
);

`default_nettype wire

// File: test/lacd_scoreboard.sv
// Dispatch predictor and result scoreboard for the cluster dispatcher testbench.
// Depends on lacd_pkg.
`timescale 1ns / 1ps

class lacd_scoreboard;
    typedef struct packed {
        logic            is_load;
        logic [3:0]      target_cluster;
        logic [9:0]      loaded_id;
        logic            last;
    } dispatch_t;

    bit          held_valid[1024];
    logic [3:0]  held_by[1024];
    bit [31:0]   class_cnt[64];
    bit [31:0]   total_cnt[16];
    int unsigned clusters_cfg;
    dispatch_t   pending[$];
    int          errors;

    function new();
        clusters_cfg = 16;
        errors = 0;
    endfunction

    function void set_clusters(int unsigned v);
        clusters_cfg = v & 5'h1f;
    endfunction

    function void bump(int c, int cls);
        if (class_cnt[c*4+cls] != 32'hffff_ffff) class_cnt[c*4+cls]++;
        if (total_cnt[c] != 32'hffff_ffff) total_cnt[c]++;
    endfunction

    // Predict the loads and the instruction result caused by one instruction.
    function void note_instr(logic [2:0] op, logic [9:0] sid[3], logic [1:0] sk[3],
                             logic [9:0] dst);
        int unsigned eff, maxc, best, bp, bt, cls;
        int unsigned cnt[16];
        bit have, need;
        dispatch_t d;
        eff = clusters_cfg;
        if (eff < 1) eff = 1;
        if (eff > 16) eff = 16;
        cls = lacd_pkg::pipe_class(op);
        foreach (cnt[c]) cnt[c] = 0;
        for (int s = 0; s < 3; s++)
            if (sk[s] == lacd_pkg::SRC_DATA && held_valid[sid[s]] && held_by[sid[s]] < eff)
                cnt[held_by[sid[s]]]++;
        maxc = 0;
        for (int c = 0; c < eff; c++) if (cnt[c] > maxc) maxc = cnt[c];
        have = 0; best = 0; bp = 0; bt = 0;
        for (int c = 0; c < eff; c++) begin
            if (maxc > 0 && cnt[c] != maxc) continue;
            if (!have || class_cnt[c*4+cls] < bp ||
                (class_cnt[c*4+cls] == bp && total_cnt[c] < bt))
            begin
                have = 1; best = c; bp = class_cnt[c*4+cls]; bt = total_cnt[c];
            end
        end
        for (int s = 0; s < 3; s++) begin
            if (sk[s] != lacd_pkg::SRC_DATA) continue;
            if (!held_valid[sid[s]]) begin
                need = 1;
                held_valid[sid[s]] = 1;
                held_by[sid[s]] = best;
            end
            else need = (held_by[sid[s]] != best);
            if (need) begin
                d = '{1'b1, best[3:0], sid[s], 1'b0};
                pending = {pending, d};
                bump(best, lacd_pkg::CLS_MISC);
            end
        end
        d = '{1'b0, best[3:0], 10'd0, 1'b1};
        pending = {pending, d};
        bump(best, cls);
        held_valid[dst] = 1;
        held_by[dst] = best;
    endfunction

    function void check_result(logic il, logic [3:0] tc, logic [9:0] lid, logic lst);
        dispatch_t e;
        if (pending.size() == 0) begin
            $error("unexpected result load=%0d cluster=%0d id=%0d", il, tc, lid);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (il !== e.is_load) begin
            $error("is_load exp %0d got %0d", e.is_load, il); errors++;
        end
        if (tc !== e.target_cluster) begin
            $error("target_cluster exp %0d got %0d", e.target_cluster, tc); errors++;
        end
        if (lid !== e.loaded_id) begin
            $error("loaded_id exp %0d got %0d", e.loaded_id, lid); errors++;
        end
        if (lst !== e.last) begin
            $error("last exp %0d got %0d", e.last, lst); errors++;
        end
    endfunction
endclass

// File: test/testbench.sv
// Top-level testbench for the locality-aware cluster dispatcher: directed and
// random instructions, random stalls, APB writes of the cluster count.
// Depends on lacd_pkg, lacd_if, lacd_scoreboard and the dispatcher RTL.
`timescale 1ns / 1ps

module testbench;
    import lacd_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    lacd_in_if  instr();
    lacd_out_if result();

    lacd_scoreboard board = new();
    int idle_cycles = 0;
    bit drain_en = 0;
    logic [9:0] pool[16];

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    locality_aware_cluster_dispatcher u_dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .instr(instr.sink), .result(result.source)
    );

    initial
    begin
        instr.valid = 0; instr.op_kind = '0; instr.dst_id = '0;
        instr.src0_id = '0; instr.src0_kind = '0; instr.src1_id = '0;
        instr.src1_kind = '0; instr.src2_id = '0; instr.src2_kind = '0;
        result.ready = 0;
    end

    // Random gap length: mostly short, a few long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Check every result transaction at the rising edge; drive ready at the falling one.
    always @(posedge clk)
    begin
        if (result.valid && result.ready)
            board.check_result(result.is_load, result.target_cluster, result.loaded_id,
                               result.last);
        if ((result.valid && result.ready) || (instr.valid && instr.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int g;
        @(negedge clk);
        forever
        begin
            g = drain_en ? gap_len() : 0;
            if (g > 0)
            begin
                result.ready <= 0;
                repeat (g) @(negedge clk);
            end
            result.ready <= 1;
            @(negedge clk);
        end
    end

    always @(posedge clk)
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end

    // Write one register through the setup and access phases.
    task automatic reg_write(input logic [APB_AW-1:0] a, input logic [APB_DW-1:0] v);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= v;
        @(negedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (a == ADDR_CLUSTERS_IN_USE) board.set_clusters(v);
    endtask

    // Hold one instruction until accepted, then note it for prediction.
    // Valid stays high after the transaction until the next instruction or a drain.
    task automatic send_instr(input logic [2:0] op, input logic [9:0] i0, input logic [1:0] k0,
                              input logic [9:0] i1, input logic [1:0] k1,
                              input logic [9:0] i2, input logic [1:0] k2,
                              input logic [9:0] dst);
        logic [9:0] ids[3];
        logic [1:0] ks[3];
        int g;
        g = gap_len();
        if (g > 0)
        begin
            instr.valid <= 0;
            repeat (g) @(negedge clk);
        end
        instr.valid <= 1; instr.op_kind <= op; instr.dst_id <= dst;
        instr.src0_id <= i0; instr.src0_kind <= k0;
        instr.src1_id <= i1; instr.src1_kind <= k1;
        instr.src2_id <= i2; instr.src2_kind <= k2;
        @(posedge clk);
        while (!instr.ready) @(posedge clk);
        ids = '{i0, i1, i2};
        ks = '{k0, k1, k2};
        board.note_instr(op, ids, ks, dst);
        @(negedge clk);
    endtask

    // Wait until every expected result is in, then let the block go idle.
    task automatic drain();
        instr.valid <= 0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    // Pick a source: mostly a data id from a small pool so locality builds up.
    task automatic rand_src(output logic [9:0] id, output logic [1:0] k);
        int r;
        r = $urandom_range(0, 99);
        id = (r < 70) ? pool[$urandom_range(0, 15)] : 10'($urandom);
        if (r < 75) k = SRC_DATA;
        else if (r < 85) k = SRC_LITERAL;
        else if (r < 95) k = SRC_ABSENT;
        else k = 2'd3;
    endtask

    task automatic random_phase(input int n);
        logic [9:0] a, b, c, d;
        logic [1:0] ka, kb, kc;
        for (int i = 0; i < n; i++)
        begin
            rand_src(a, ka); rand_src(b, kb); rand_src(c, kc);
            d = ($urandom_range(0, 3) == 0) ? 10'($urandom) : pool[$urandom_range(0, 15)];
            send_instr(3'($urandom_range(0, 7)), a, ka, b, kb, c, kc, d);
        end
    endtask

    initial
    begin
        foreach (pool[i]) pool[i] = 10'($urandom);
        repeat (9) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);
        drain_en = 1;

        // Directed: every op, all operand kinds, extremes of ids, repeated sources.
        send_instr(OP_NTT, 10'd0, SRC_DATA, 10'd1023, SRC_DATA, 10'd0, SRC_DATA, 10'd1023);
        send_instr(OP_INTT, 10'd0, SRC_DATA, 10'd1023, SRC_LITERAL, 10'd5, SRC_ABSENT, 10'd7);
        send_instr(OP_MODMUL, 10'd1023, SRC_DATA, 10'd7, SRC_DATA, 10'd9, 2'd3, 10'd0);
        send_instr(OP_MODADD, 10'd7, SRC_DATA, 10'd7, SRC_DATA, 10'd7, SRC_DATA, 10'd512);
        send_instr(OP_LOAD, 10'd0, SRC_ABSENT, 10'd0, SRC_ABSENT, 10'd0, SRC_ABSENT, 10'd3);
        send_instr(OP_OTHER, 10'd512, SRC_DATA, 10'd3, SRC_DATA, 10'd0, SRC_DATA, 10'd1);
        send_instr(3'd6, 10'd1, SRC_DATA, 10'h2AA, SRC_LITERAL, 10'h155, SRC_DATA, 10'h155);
        send_instr(3'd7, 10'h155, SRC_DATA, 10'h2AA, SRC_DATA, 10'd1, 2'd3, 10'h2AA);
        for (int i = 0; i < 6; i++)
            send_instr(3'(i), 10'(i), SRC_DATA, 10'(i + 1), SRC_DATA, 10'd1023, SRC_DATA, 10'(i));
        drain();

        // One cluster only, then residency on clusters now out of use.
        reg_write(ADDR_CLUSTERS_IN_USE, 32'd1);
        random_phase(40);
        drain();
        reg_write(ADDR_CLUSTERS_IN_USE, 32'd0);
        random_phase(20);
        drain();
        reg_write(ADDR_CLUSTERS_IN_USE, 32'd31);
        random_phase(60);
        drain();
        reg_write(ADDR_CLUSTERS_IN_USE, 32'd3);
        random_phase(60);
        drain();
        reg_write(ADDR_CLUSTERS_IN_USE, 32'($urandom_range(2, 16)));
        random_phase(60);
        drain();
        reg_write(ADDR_CLUSTERS_IN_USE, 32'd16);
        random_phase(60);
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// File: files.f
rtl/lacd_pkg.sv
rtl/lacd_if.sv
rtl/lacd_ram.sv
rtl/locality_aware_cluster_dispatcher.sv
rtl/lacd_checker.sv
test/lacd_scoreboard.sv
test/testbench.sv
